[design/ilud_pkg.sv]
// ----------------------------------------------------------------------------
// ilud_pkg
// Shared widths, codes, types and fixed-point helpers for the iterative
// inverse lens distortion block.
// ----------------------------------------------------------------------------
package ilud_pkg;

  localparam int COORD_W       = 32;
  localparam int FOCAL_W       = 64;
  localparam int CFG_IDX_W     = 4;
  localparam int OUTCOME_W     = 2;
  localparam int MAX_STEPS_DEF = 100;

  localparam int NUM_W  = 35;  // divider numerator, signed
  localparam int DIVD_W = 59;  // divider dividend, (|num| << 24) + den/2
  localparam int MOP_W  = 33;  // multiplier operand, signed
  localparam int PROD_W = 66;
  localparam int ACC_W  = 36;
  localparam int ERR_W  = 32;
  localparam int MAG_W  = 38;  // |50 * error delta|
  localparam int PT_W   = 34;  // evaluation point, p or p + step
  localparam int SAT_W  = 48;  // width handed to the saturating helper

  localparam logic [ERR_W-1:0]          TOL_Q16  = 32'd3277;
  localparam logic signed [COORD_W-1:0] STEP_Q16 = 32'sd655;
  localparam logic signed [ACC_W-1:0]   ONE_Q24  = 36'sd16777216;
  localparam logic signed [COORD_W-1:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] S32_MIN  = 32'sh8000_0000;
  localparam logic [FOCAL_W-1:0]        FOCAL_RESET = 64'h0001_0000_0001_0000;

  typedef logic signed [COORD_W-1:0] s32_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_CONVERGED  = 2'd0,
    OUT_STEP_LIMIT = 2'd1,
    OUT_OVERFLOW   = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1    = 4'd0,
    CFG_K2    = 4'd1,
    CFG_K3    = 4'd2,
    CFG_P1    = 4'd3,
    CFG_P2    = 4'd4,
    CFG_CX    = 4'd5,
    CFG_CY    = 4'd6,
    CFG_FOCAL = 4'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_DIVY, S_XX, S_YY, S_XY, S_R4, S_R6,
    S_K1, S_K2, S_K3, S_P1XY, S_P2W, S_P2XY, S_P1W, S_RXC, S_RYC,
    S_SCX, S_SCY, S_EVAL, S_UXL, S_UXH, S_UYL, S_UYH, S_UPD, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    s32_t        k1;
    s32_t        k2;
    s32_t        k3;
    s32_t        p1;
    s32_t        p2;
    s32_t        cx;
    s32_t        cy;
    logic [31:0] fx;
    logic [31:0] fy;
  } lens_cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [31:0]             den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ov;
    s32_t q;
  } div_rsp_t;

  typedef struct packed {
    s32_t     x;
    s32_t     y;
    outcome_t outcome;
  } point_res_t;

  typedef struct packed {
    logic ov;
    s32_t v;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] x);
    sat_t r;
    if (x > SAT_W'(S32_MAX)) begin
      r.ov = 1'b1;
      r.v  = S32_MAX;
    end else if (x < SAT_W'(S32_MIN)) begin
      r.ov = 1'b1;
      r.v  = S32_MIN;
    end else begin
      r.ov = 1'b0;
      r.v  = x[COORD_W-1:0];
    end
    return r;
  endfunction

  // Q8.24 product: round half up, floor shift, saturate
  function automatic sat_t mulq_fix(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] t;
    t = (prod + PROD_W'(64'sd8388608)) >>> 24;
    return sat32(t[SAT_W-1:0]);
  endfunction

endpackage

[design/ilud_in_if.sv]
// ----------------------------------------------------------------------------
// ilud_in_if
// Target point channel: valid/ready with the distorted target coordinate.
// ----------------------------------------------------------------------------
interface ilud_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ilud_pkg::COORD_W-1:0]  target_x;
  logic signed [ilud_pkg::COORD_W-1:0]  target_y;

  modport source (output valid, target_x, target_y, input ready);
  modport sink   (input valid, target_x, target_y, output ready);
endinterface

[design/ilud_out_if.sv]
// ----------------------------------------------------------------------------
// ilud_out_if
// Result channel: valid/ready with the undistorted estimate and status.
// ----------------------------------------------------------------------------
interface ilud_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ilud_pkg::COORD_W-1:0]  found_x;
  logic signed [ilud_pkg::COORD_W-1:0]  found_y;
  logic [ilud_pkg::OUTCOME_W-1:0]       outcome;

  modport source (output valid, found_x, found_y, outcome, input ready);
  modport sink   (input valid, found_x, found_y, outcome, output ready);
endinterface

[design/inverse_lens_undistort_point.sv]
// ----------------------------------------------------------------------------
// inverse_lens_undistort_point
// Iterative inverse of a Brown-Conrady lens model for one pixel at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready transfer of a distorted target (target_x/y, Q16.16).
//   out_ch : valid/ready transfer of found_x/y (Q16.16) and outcome
//            (converged, step limit, overflow). One result per target.
//   cfg_*  : write-only register port; write only while the block is idle.
//            Index 0..6 take the low 32 bits of cfg_data, index 7 all 64.
// Schedule: one model evaluation runs two passes of the 59-step radix-2
//   divider, one per axis, then its multiplies on the one shared 33x33
//   unit. An item that converges at once takes a single evaluation; each
//   further search step adds two evaluations and the update, and a search
//   runs at most MAX_STEPS+1 steps.
// Throughput: one target at a time; in_ch.ready is high only while idle.
//   A finished result waits in the output register so the next target can
//   start while the receiver stalls.
// Reset: synchronous, active low; clears the sequencer and output valid and
//   loads the registers with zero coefficients and unit focal lengths.
// ----------------------------------------------------------------------------
module inverse_lens_undistort_point #(
  parameter int MAX_STEPS = ilud_pkg::MAX_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ilud_in_if.sink                          in_ch,
  ilud_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ilud_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ilud_pkg::FOCAL_W-1:0]     cfg_data
);
  import ilud_pkg::*;

  localparam lens_cfg_t LENS_RESET = '{
    k1: '0, k2: '0, k3: '0, p1: '0, p2: '0, cx: '0, cy: '0,
    fx: FOCAL_RESET[31:0], fy: FOCAL_RESET[63:32]
  };

  lens_cfg_t  lens_r, lens_nxt;
  logic       out_valid_r, out_valid_nxt;
  point_res_t out_r, out_nxt;

  logic       idle;
  logic       start;
  logic       res_valid;
  logic       res_ready;
  point_res_t res;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic signed [MOP_W-1:0]  mul_a;
  logic signed [MOP_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  assign in_ch.ready    = idle;
  assign start          = in_ch.valid & idle;
  assign res_ready      = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.found_x = out_r.x;
  assign out_ch.found_y = out_r.y;
  assign out_ch.outcome = out_r.outcome;

  always_comb begin
    lens_nxt = lens_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_K1:    lens_nxt.k1 = cfg_data[31:0];
        CFG_K2:    lens_nxt.k2 = cfg_data[31:0];
        CFG_K3:    lens_nxt.k3 = cfg_data[31:0];
        CFG_P1:    lens_nxt.p1 = cfg_data[31:0];
        CFG_P2:    lens_nxt.p2 = cfg_data[31:0];
        CFG_CX:    lens_nxt.cx = cfg_data[31:0];
        CFG_CY:    lens_nxt.cy = cfg_data[31:0];
        CFG_FOCAL: begin
          lens_nxt.fx = cfg_data[31:0];
          lens_nxt.fy = cfg_data[63:32];
        end
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lens_r      <= LENS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      lens_r      <= lens_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  ilud_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ilud_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ilud_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .lens      (lens_r),
    .start     (start),
    .target_x  (in_ch.target_x),
    .target_y  (in_ch.target_y),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .prod      (prod)
  );

endmodule

[design/ilud_div.sv]
// ----------------------------------------------------------------------------
// ilud_div
// Radix-2 restoring divider: signed Q16.16 numerator over unsigned Q16.16
// focal length, rounded half away from zero, saturated to signed Q8.24.
// ----------------------------------------------------------------------------
module ilud_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ilud_pkg::div_req_t  req,
  output ilud_pkg::div_rsp_t  rsp
);
  import ilud_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [DIVD_W-1:0] dq_r, dq_nxt;
  logic [31:0]       den_r, den_nxt;
  logic              neg_r, neg_nxt;
  div_rsp_t          rsp_r, rsp_nxt;

  logic [PT_W-1:0]   mag;
  logic [32:0]       shl;
  logic              ge;
  logic              big;

  assign rsp = rsp_r;

  always_comb begin
    mag = req.num[NUM_W-1] ? PT_W'(-req.num) : PT_W'(req.num);
    shl = {rem_r, dq_r[DIVD_W-1]};
    ge  = (shl >= {1'b0, den_r});
    big = |dq_r[DIVD_W-1:32];
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    rsp_nxt  = rsp_r;
    rsp_nxt.done = 1'b0;
    if (req.start) begin
      neg_nxt = req.num[NUM_W-1];
      den_nxt = req.den;
      if (req.den == '0) begin
        // zero focal: flag it, sign of the numerator
        rsp_nxt.done = 1'b1;
        rsp_nxt.ov   = 1'b1;
        if (req.num[NUM_W-1])  rsp_nxt.q = S32_MIN;
        else if (req.num != '0) rsp_nxt.q = S32_MAX;
        else                    rsp_nxt.q = '0;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = CNT_W'(DIVD_W);
        rem_nxt  = '0;
        dq_nxt   = {mag, 24'b0} + DIVD_W'(req.den >> 1);
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_nxt = ge ? 32'(shl - {1'b0, den_r}) : shl[31:0];
        dq_nxt  = {dq_r[DIVD_W-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        busy_nxt     = 1'b0;
        rsp_nxt.done = 1'b1;
        if (neg_r) begin
          rsp_nxt.ov = big | (dq_r[31] & (|dq_r[30:0]));
          rsp_nxt.q  = rsp_nxt.ov ? S32_MIN : -$signed(dq_r[31:0]);
        end else begin
          rsp_nxt.ov = big | dq_r[31];
          rsp_nxt.q  = rsp_nxt.ov ? S32_MAX : $signed(dq_r[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rsp_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rsp_r  <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

endmodule

[design/ilud_mul.sv]
// ----------------------------------------------------------------------------
// ilud_mul
// Shared 33x33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ilud_mul (
  input  logic                                clk,
  input  logic signed [ilud_pkg::MOP_W-1:0]   a,
  input  logic signed [ilud_pkg::MOP_W-1:0]   b,
  output logic signed [ilud_pkg::PROD_W-1:0]  prod
);
  import ilud_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  assign prod = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

[design/ilud_ctrl.sv]
// ----------------------------------------------------------------------------
// ilud_ctrl
// Sequencer and register file of the search: runs the distortion model on
// the shared divider and multiplier, then the error-driven update.
// ----------------------------------------------------------------------------
module ilud_ctrl #(
  parameter int MAX_STEPS = ilud_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ilud_pkg::lens_cfg_t                 lens,
  input  logic                                start,
  input  ilud_pkg::s32_t                      target_x,
  input  ilud_pkg::s32_t                      target_y,
  output logic                                idle,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ilud_pkg::point_res_t                res,
  output ilud_pkg::div_req_t                  div_req,
  input  ilud_pkg::div_rsp_t                  div_rsp,
  output logic signed [ilud_pkg::MOP_W-1:0]   mul_a,
  output logic signed [ilud_pkg::MOP_W-1:0]   mul_b,
  input  logic signed [ilud_pkg::PROD_W-1:0]  prod
);
  import ilud_pkg::*;

  localparam int STEP_W = $clog2(MAX_STEPS + 2);

  ctrl_state_t state_r, state_nxt;
  logic        ph_r, ph_nxt;
  logic        pass_r, pass_nxt;
  logic        ov_r, ov_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  outcome_t    outcome_r, outcome_nxt;

  s32_t tx_r, tx_nxt, ty_r, ty_nxt, px_r, px_nxt, py_r, py_nxt;
  logic signed [PT_W-1:0] ptx_r, ptx_nxt, pty_r, pty_nxt;
  s32_t rx_r, rx_nxt, ry_r, ry_nxt, xx_r, xx_nxt, yy_r, yy_nxt, xy_r, xy_nxt;
  s32_t r2_r, r2_nxt, r4_r, r4_nxt, r6_r, r6_nxt, cr_r, cr_nxt, w_r, w_nxt;
  s32_t dx_r, dx_nxt, dy_r, dy_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  s32_t ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ERR_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [MAG_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic             negx_r, negx_nxt, negy_r, negy_nxt;
  logic [63:0]      lo_r, lo_nxt;

  sat_t             mq;
  logic [ERR_W-1:0] ex_now, ey_now;
  logic             converged;
  logic [STEP_W-1:0] steps_inc;
  logic             step_last;
  logic signed [39:0] dx50, dy50;

  function automatic logic [ERR_W-1:0] err_mag(input s32_t a, input s32_t b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? ERR_W'(-d) : d[ERR_W-1:0];
  endfunction

  // 50 * (eh - e)
  function automatic logic signed [39:0] gain50(input logic [ERR_W-1:0] eh,
                                                input logic [ERR_W-1:0] e);
    logic signed [39:0] d;
    d = 40'($signed({1'b0, eh})) - 40'($signed({1'b0, e}));
    return (d <<< 5) + (d <<< 4) + (d <<< 1);
  endfunction

  function automatic logic [MAG_W-1:0] mag40(input logic signed [39:0] d);
    return d[39] ? MAG_W'(-d) : d[MAG_W-1:0];
  endfunction

  // Q8.24 magnitude times Q16.16 focal, signed, plus centre
  function automatic sat_t rescale(input logic [63:0] pr, input logic neg,
                                   input s32_t c);
    logic [63:0] t;
    logic signed [SAT_W-1:0] v;
    t = pr + 64'd8388608;
    v = $signed({8'b0, t[63:24]});
    if (neg) v = -v;
    return sat32(v + SAT_W'(c));
  endfunction

  // p - sign * round(m * e / 2^16), clipped when m * e exceeds 2^47
  function automatic sat_t apply_update(input s32_t p, input logic neg,
                                        input logic [63:0] lo,
                                        input logic [MAG_W-1:0] hi);
    logic [70:0] big;
    logic [70:0] rnd;
    logic        uov;
    logic [31:0] g;
    logic signed [SAT_W-1:0] np;
    sat_t        r;
    big = {7'b0, lo} + {1'b0, hi, 32'b0};
    uov = (big > 71'h8000_0000_0000);
    rnd = big + 71'd32768;
    g   = uov ? 32'h8000_0000 : rnd[47:16];
    if (neg) np = SAT_W'(p) + SAT_W'($signed({1'b0, g}));
    else     np = SAT_W'(p) - SAT_W'($signed({1'b0, g}));
    r = sat32(np);
    r.ov = r.ov | uov;
    return r;
  endfunction

  function automatic ctrl_state_t step_after(input ctrl_state_t s);
    ctrl_state_t n;
    case (s)
      S_XX:    n = S_YY;
      S_YY:    n = S_XY;
      S_XY:    n = S_R4;
      S_R4:    n = S_R6;
      S_R6:    n = S_K1;
      S_K1:    n = S_K2;
      S_K2:    n = S_K3;
      S_K3:    n = S_P1XY;
      S_P1XY:  n = S_P2W;
      S_P2W:   n = S_P2XY;
      S_P2XY:  n = S_P1W;
      S_P1W:   n = S_RXC;
      S_RXC:   n = S_RYC;
      S_RYC:   n = S_SCX;
      S_SCX:   n = S_SCY;
      S_SCY:   n = S_EVAL;
      S_UXL:   n = S_UXH;
      S_UXH:   n = S_UYL;
      S_UYL:   n = S_UYH;
      S_UYH:   n = S_UPD;
      default: n = S_IDLE;
    endcase
    return n;
  endfunction

  always_comb begin
    mq        = mulq_fix(prod);
    ex_now    = err_mag(ux_r, tx_r);
    ey_now    = err_mag(uy_r, ty_r);
    converged = (ex_now < TOL_Q16) && (ey_now < TOL_Q16);
    steps_inc = steps_r + STEP_W'(1);
    step_last = (steps_inc > STEP_W'(MAX_STEPS));
    dx50      = gain50(ex_now, ex_r);
    dy50      = gain50(ey_now, ey_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    case (state_r) inside
      S_IDLE: begin
        ph_nxt = 1'b0;
        if (start) state_nxt = S_DIVX;
      end
      S_DIVX, S_DIVY: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else if (div_rsp.done) begin
          ph_nxt    = 1'b0;
          state_nxt = (state_r == S_DIVX) ? S_DIVY : S_XX;
        end
      end
      [S_XX:S_SCY], [S_UXL:S_UYH]: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          state_nxt = step_after(state_r);
        end
      end
      S_EVAL: begin
        if (pass_r)                  state_nxt = S_UXL;
        else if (ov_r || converged)  state_nxt = S_DONE;
        else                         state_nxt = S_DIVX;
      end
      S_UPD: begin
        state_nxt = (ov_r || step_last) ? S_DONE : S_DIVX;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit operands and handshake outputs
  always_comb begin
    idle      = (state_r == S_IDLE);
    res_valid = (state_r == S_DONE);
    res.x       = px_r;
    res.y       = py_r;
    res.outcome = outcome_r;

    div_req.start = ((state_r == S_DIVX) || (state_r == S_DIVY)) && !ph_r;
    if (state_r == S_DIVY) begin
      div_req.num = NUM_W'(pty_r) - NUM_W'(lens.cy);
      div_req.den = lens.fy;
    end else begin
      div_req.num = NUM_W'(ptx_r) - NUM_W'(lens.cx);
      div_req.den = lens.fx;
    end

    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_XX:   begin mul_a = MOP_W'(rx_r);  mul_b = MOP_W'(rx_r); end
      S_YY:   begin mul_a = MOP_W'(ry_r);  mul_b = MOP_W'(ry_r); end
      S_XY:   begin mul_a = MOP_W'(rx_r);  mul_b = MOP_W'(ry_r); end
      S_R4:   begin mul_a = MOP_W'(r2_r);  mul_b = MOP_W'(r2_r); end
      S_R6:   begin mul_a = MOP_W'(r4_r);  mul_b = MOP_W'(r2_r); end
      S_K1:   begin mul_a = MOP_W'(lens.k1); mul_b = MOP_W'(r2_r); end
      S_K2:   begin mul_a = MOP_W'(lens.k2); mul_b = MOP_W'(r4_r); end
      S_K3:   begin mul_a = MOP_W'(lens.k3); mul_b = MOP_W'(r6_r); end
      S_P1XY: begin mul_a = MOP_W'(lens.p1); mul_b = MOP_W'(xy_r); end
      S_P2W:  begin mul_a = MOP_W'(lens.p2); mul_b = MOP_W'(w_r);  end
      S_P2XY: begin mul_a = MOP_W'(lens.p2); mul_b = MOP_W'(xy_r); end
      S_P1W:  begin mul_a = MOP_W'(lens.p1); mul_b = MOP_W'(w_r);  end
      S_RXC:  begin mul_a = MOP_W'(rx_r);  mul_b = MOP_W'(cr_r); end
      S_RYC:  begin mul_a = MOP_W'(ry_r);  mul_b = MOP_W'(cr_r); end
      S_SCX: begin
        mul_a = {1'b0, (ax_r[31] ? 32'(-ax_r) : 32'(ax_r))};
        mul_b = {1'b0, lens.fx};
      end
      S_SCY: begin
        mul_a = {1'b0, (ay_r[31] ? 32'(-ay_r) : 32'(ay_r))};
        mul_b = {1'b0, lens.fy};
      end
      S_UXL: begin mul_a = {1'b0, mx_r[31:0]};        mul_b = {1'b0, ex_r}; end
      S_UXH: begin mul_a = MOP_W'(mx_r[MAG_W-1:32]);  mul_b = {1'b0, ex_r}; end
      S_UYL: begin mul_a = {1'b0, my_r[31:0]};        mul_b = {1'b0, ey_r}; end
      S_UYH: begin mul_a = MOP_W'(my_r[MAG_W-1:32]);  mul_b = {1'b0, ey_r}; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    sat_t s;
    s = '0;
    pass_nxt = pass_r;  ov_nxt = ov_r;  steps_nxt = steps_r;
    outcome_nxt = outcome_r;
    tx_nxt = tx_r;  ty_nxt = ty_r;  px_nxt = px_r;  py_nxt = py_r;
    ptx_nxt = ptx_r;  pty_nxt = pty_r;
    rx_nxt = rx_r;  ry_nxt = ry_r;  xx_nxt = xx_r;  yy_nxt = yy_r;  xy_nxt = xy_r;
    r2_nxt = r2_r;  r4_nxt = r4_r;  r6_nxt = r6_r;  cr_nxt = cr_r;  w_nxt = w_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;  ax_nxt = ax_r;  ay_nxt = ay_r;
    ux_nxt = ux_r;  uy_nxt = uy_r;  acc_nxt = acc_r;
    ex_nxt = ex_r;  ey_nxt = ey_r;  mx_nxt = mx_r;  my_nxt = my_r;
    negx_nxt = negx_r;  negy_nxt = negy_r;  lo_nxt = lo_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          tx_nxt = target_x;  ty_nxt = target_y;
          px_nxt = target_x;  py_nxt = target_y;
          ptx_nxt = PT_W'(target_x);
          pty_nxt = PT_W'(target_y);
          pass_nxt = 1'b0;  ov_nxt = 1'b0;  steps_nxt = '0;
        end
      end
      S_DIVX: if (ph_r && div_rsp.done) begin
        rx_nxt = div_rsp.q;  ov_nxt = ov_r | div_rsp.ov;
      end
      S_DIVY: if (ph_r && div_rsp.done) begin
        ry_nxt = div_rsp.q;  ov_nxt = ov_r | div_rsp.ov;
      end
      S_XX: if (ph_r) begin xx_nxt = mq.v; ov_nxt = ov_r | mq.ov; end
      S_YY: if (ph_r) begin yy_nxt = mq.v; ov_nxt = ov_r | mq.ov; end
      S_XY: if (ph_r) begin
        xy_nxt = mq.v;
        s = sat32(SAT_W'(xx_r) + SAT_W'(yy_r));
        r2_nxt = s.v;
        ov_nxt = ov_r | mq.ov | s.ov;
      end
      S_R4: if (ph_r) begin r4_nxt = mq.v; ov_nxt = ov_r | mq.ov; end
      S_R6: if (ph_r) begin r6_nxt = mq.v; ov_nxt = ov_r | mq.ov; end
      S_K1: if (ph_r) begin
        acc_nxt = ONE_Q24 + ACC_W'(mq.v);  ov_nxt = ov_r | mq.ov;
      end
      S_K2: if (ph_r) begin
        acc_nxt = acc_r + ACC_W'(mq.v);  ov_nxt = ov_r | mq.ov;
      end
      S_K3: if (ph_r) begin
        s = sat32(SAT_W'(acc_r) + SAT_W'(mq.v));
        cr_nxt = s.v;  ov_nxt = ov_r | mq.ov | s.ov;
      end
      S_P1XY, S_P2XY: if (ph_r) begin
        acc_nxt = ACC_W'(mq.v) <<< 1;
        if (state_r == S_P1XY) s = sat32(SAT_W'(r2_r) + (SAT_W'(xx_r) <<< 1));
        else                   s = sat32(SAT_W'(r2_r) + (SAT_W'(yy_r) <<< 1));
        w_nxt  = s.v;
        ov_nxt = ov_r | mq.ov | s.ov;
      end
      S_P2W, S_P1W: if (ph_r) begin
        s = sat32(SAT_W'(acc_r) + SAT_W'(mq.v));
        if (state_r == S_P2W) dx_nxt = s.v;
        else                  dy_nxt = s.v;
        ov_nxt = ov_r | mq.ov | s.ov;
      end
      S_RXC: if (ph_r) begin
        s = sat32(SAT_W'(mq.v) + SAT_W'(dx_r));
        ax_nxt = s.v;  ov_nxt = ov_r | mq.ov | s.ov;
      end
      S_RYC: if (ph_r) begin
        s = sat32(SAT_W'(mq.v) + SAT_W'(dy_r));
        ay_nxt = s.v;  ov_nxt = ov_r | mq.ov | s.ov;
      end
      S_SCX: if (ph_r) begin
        s = rescale(prod[63:0], ax_r[31], lens.cx);
        ux_nxt = s.v;  ov_nxt = ov_r | s.ov;
      end
      S_SCY: if (ph_r) begin
        s = rescale(prod[63:0], ay_r[31], lens.cy);
        uy_nxt = s.v;  ov_nxt = ov_r | s.ov;
      end
      S_EVAL: begin
        if (!pass_r) begin
          ex_nxt = ex_now;
          ey_nxt = ey_now;
          if (ov_r)           outcome_nxt = OUT_OVERFLOW;
          else if (converged) outcome_nxt = OUT_CONVERGED;
          else begin
            // second evaluation one difference step ahead
            pass_nxt = 1'b1;
            ptx_nxt  = PT_W'(px_r) + PT_W'(STEP_Q16);
            pty_nxt  = PT_W'(py_r) + PT_W'(STEP_Q16);
          end
        end else begin
          negx_nxt = dx50[39];  mx_nxt = mag40(dx50);
          negy_nxt = dy50[39];  my_nxt = mag40(dy50);
        end
      end
      S_UXL, S_UYL: if (ph_r) lo_nxt = prod[63:0];
      S_UXH: if (ph_r) begin
        s = apply_update(px_r, negx_r, lo_r, prod[MAG_W-1:0]);
        px_nxt = s.v;  ov_nxt = ov_r | s.ov;
      end
      S_UYH: if (ph_r) begin
        s = apply_update(py_r, negy_r, lo_r, prod[MAG_W-1:0]);
        py_nxt = s.v;  ov_nxt = ov_r | s.ov;
      end
      S_UPD: begin
        steps_nxt = steps_inc;
        if (ov_r)           outcome_nxt = OUT_OVERFLOW;
        else if (step_last) outcome_nxt = OUT_STEP_LIMIT;
        else begin
          pass_nxt = 1'b0;
          ov_nxt   = 1'b0;
          ptx_nxt  = PT_W'(px_r);
          pty_nxt  = PT_W'(py_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt;  ov_r <= ov_nxt;  steps_r <= steps_nxt;
    outcome_r <= outcome_nxt;
    tx_r <= tx_nxt;  ty_r <= ty_nxt;  px_r <= px_nxt;  py_r <= py_nxt;
    ptx_r <= ptx_nxt;  pty_r <= pty_nxt;
    rx_r <= rx_nxt;  ry_r <= ry_nxt;  xx_r <= xx_nxt;  yy_r <= yy_nxt;
    xy_r <= xy_nxt;  r2_r <= r2_nxt;  r4_r <= r4_nxt;  r6_r <= r6_nxt;
    cr_r <= cr_nxt;  w_r <= w_nxt;  dx_r <= dx_nxt;  dy_r <= dy_nxt;
    ax_r <= ax_nxt;  ay_r <= ay_nxt;  ux_r <= ux_nxt;  uy_r <= uy_nxt;
    acc_r <= acc_nxt;  ex_r <= ex_nxt;  ey_r <= ey_nxt;
    mx_r <= mx_nxt;  my_r <= my_nxt;  negx_r <= negx_nxt;  negy_r <= negy_nxt;
    lo_r <= lo_nxt;
  end

endmodule
